### hw/rtl/bict_pkg.sv
package bict_pkg;

  // coordinate and field widths
  localparam int COORD_W = 9;
  localparam int FUNC_W  = 2;
  // width for comparing against the largest image dimension (4096)
  localparam int LIM_W   = 13;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic [COORD_W-1:0] DIM_RESET = 9'd256;

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd2;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // headings
  localparam logic [1:0] HEAD_N = 2'd0;
  localparam logic [1:0] HEAD_E = 2'd1;
  localparam logic [1:0] HEAD_S = 2'd2;
  localparam logic [1:0] HEAD_W = 2'd3;

  // pixel store access, one per cycle
  typedef struct packed {
    logic               rd;
    logic               we;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               black;
  } pix_req_t;

  // controller status seen by the top level
  typedef struct packed {
    logic busy;
    logic active;
  } ctrl_stat_t;

  // front-left pixel offset {dx, dy} from a corner for a heading
  function automatic logic [1:0] fl_off(input logic [1:0] head);
    logic [1:0] off;
    unique case (head)
      HEAD_N:  off = 2'b00;
      HEAD_E:  off = 2'b10;
      HEAD_S:  off = 2'b11;
      default: off = 2'b01;
    endcase
    return off;
  endfunction

endpackage

### hw/rtl/bict_pixel_mem.sv
module bict_pixel_mem #(
  parameter int MAX_WIDTH  = bict_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bict_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  bict_pkg::pix_req_t            req,
  input  logic [bict_pkg::COORD_W-1:0]  used_w,
  input  logic [bict_pkg::COORD_W-1:0]  used_h,
  output logic                          pix
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LIN_W  = 2 * bict_pkg::LIM_W;

  logic                        mem [DEPTH];
  logic [bict_pkg::LIM_W-1:0]  col_l;
  logic [bict_pkg::LIM_W-1:0]  row_l;
  logic [LIN_W-1:0]            lin;
  logic [ADDR_W-1:0]           addr;
  logic                        col_ok;
  logic                        row_ok;
  logic                        wr_ok;
  logic                        rd_in;
  logic                        rd_data;
  logic                        rd_inside;

  // linear address, row major
  assign col_l = bict_pkg::LIM_W'(req.col);
  assign row_l = bict_pkg::LIM_W'(req.row);
  assign lin   = LIN_W'(row_l - 1'b1) * LIN_W'(MAX_WIDTH) + LIN_W'(col_l - 1'b1);
  assign addr  = lin[ADDR_W-1:0];

  // writes land anywhere in the store, reads only inside the image in use
  assign col_ok = (req.col != '0) && (col_l <= bict_pkg::LIM_W'(MAX_WIDTH));
  assign row_ok = (req.row != '0) && (row_l <= bict_pkg::LIM_W'(MAX_HEIGHT));
  assign wr_ok  = req.we && col_ok && row_ok;
  assign rd_in  = (req.col != '0) && (req.row != '0) &&
                  (req.col <= used_w) && (req.row <= used_h);

  // single port store, registered read
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[addr] <= req.black;
    end
    if (req.rd) begin
      rd_data   <= mem[addr];
      rd_inside <= rd_in;
    end
  end

  // outside the image reads white
  assign pix = rd_inside & rd_data;

endmodule

### hw/rtl/bict_ctrl.sv
module bict_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bict_pkg::FUNC_W-1:0]   func,
  input  logic [bict_pkg::COORD_W-1:0]  pixel_col,
  input  logic [bict_pkg::COORD_W-1:0]  pixel_row,
  input  logic                          pixel_black,
  input  logic [bict_pkg::COORD_W-1:0]  used_w,
  input  logic [bict_pkg::COORD_W-1:0]  used_h,
  input  logic                          pix,
  output bict_pkg::pix_req_t            req,
  output bict_pkg::ctrl_stat_t          stat,
  output logic                          res_valid,
  output logic [bict_pkg::COORD_W-1:0]  res_x,
  output logic [bict_pkg::COORD_W-1:0]  res_y,
  output logic                          res_closed,
  output logic                          res_empty
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_FR   = 4'b0100,
    ST_DEC  = 4'b1000
  } state_t;

  state_t                         state;
  logic                           accept;
  logic                           active;
  logic [1:0]                     heading;
  logic [bict_pkg::COORD_W-1:0]   tracer_x;
  logic [bict_pkg::COORD_W-1:0]   tracer_y;
  logic [bict_pkg::COORD_W-1:0]   start_x;
  logic [bict_pkg::COORD_W-1:0]   start_y;
  // scan position and the read in flight
  logic [bict_pkg::COORD_W-1:0]   sc;
  logic [bict_pkg::COORD_W-1:0]   sr;
  logic                           scan_done;
  logic                           scan_issue;
  logic                           scan_last;
  logic                           pend_valid;
  logic                           pend_last;
  logic [bict_pkg::COORD_W-1:0]   pend_c;
  logic [bict_pkg::COORD_W-1:0]   pend_r;
  // step decision
  logic                           fl_black;
  logic [1:0]                     rh;
  logic [1:0]                     fl_o;
  logic [1:0]                     fr_o;
  logic [1:0]                     heading_next;
  logic [bict_pkg::COORD_W-1:0]   x_next;
  logic [bict_pkg::COORD_W-1:0]   y_next;

  assign accept     = start && (state == ST_IDLE);
  assign stat.busy  = (state != ST_IDLE);
  assign stat.active = active;

  assign scan_issue = (state == ST_SCAN) && !scan_done;
  assign scan_last  = (sc == used_w) && (sr == used_h);

  assign rh   = heading + 2'd1;
  assign fl_o = bict_pkg::fl_off(heading);
  assign fr_o = bict_pkg::fl_off(rh);

  // pixel store request
  always_comb begin
    req = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && func == bict_pkg::FUNC_WRITE) begin
          req.we    = 1'b1;
          req.col   = pixel_col;
          req.row   = pixel_row;
          req.black = pixel_black;
        end else if (accept && func == bict_pkg::FUNC_STEP && active) begin
          req.rd  = 1'b1;
          req.col = tracer_x + bict_pkg::COORD_W'(fl_o[1]);
          req.row = tracer_y + bict_pkg::COORD_W'(fl_o[0]);
        end
      end
      ST_SCAN: begin
        req.rd  = scan_issue;
        req.col = sc;
        req.row = sr;
      end
      ST_FR: begin
        req.rd  = 1'b1;
        req.col = tracer_x + bict_pkg::COORD_W'(fr_o[1]);
        req.row = tracer_y + bict_pkg::COORD_W'(fr_o[0]);
      end
      default: begin
        req = '0;
      end
    endcase
  end

  // turn, then move one corner; pix holds the front-right pixel in ST_DEC
  always_comb begin
    if (fl_black) begin
      heading_next = heading + 2'd3;
    end else if (!pix) begin
      heading_next = rh;
    end else begin
      heading_next = heading;
    end
    x_next = tracer_x;
    y_next = tracer_y;
    unique case (heading_next)
      bict_pkg::HEAD_N: y_next = tracer_y - 1'b1;
      bict_pkg::HEAD_E: x_next = tracer_x + 1'b1;
      bict_pkg::HEAD_S: y_next = tracer_y + 1'b1;
      bict_pkg::HEAD_W: x_next = tracer_x - 1'b1;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active     <= 1'b0;
      heading    <= bict_pkg::HEAD_E;
      tracer_x   <= '0;
      tracer_y   <= '0;
      start_x    <= '0;
      start_y    <= '0;
      scan_done  <= 1'b0;
      pend_valid <= 1'b0;
      pend_last  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && func == bict_pkg::FUNC_START) begin
            if (used_w == '0 || used_h == '0) begin
              active     <= 1'b0;
              res_valid  <= 1'b1;
              res_x      <= '0;
              res_y      <= '0;
              res_closed <= 1'b0;
              res_empty  <= 1'b1;
            end else begin
              sc         <= bict_pkg::COORD_W'(1);
              sr         <= bict_pkg::COORD_W'(1);
              scan_done  <= 1'b0;
              pend_valid <= 1'b0;
              state      <= ST_SCAN;
            end
          end else if (accept && func == bict_pkg::FUNC_STEP && active) begin
            state <= ST_FR;
          end
        end
        ST_SCAN: begin
          if (pend_valid && pix) begin
            // first black pixel: start on its top-left corner
            tracer_x   <= pend_c - 1'b1;
            tracer_y   <= pend_r - 1'b1;
            start_x    <= pend_c - 1'b1;
            start_y    <= pend_r - 1'b1;
            heading    <= bict_pkg::HEAD_E;
            active     <= 1'b1;
            pend_valid <= 1'b0;
            res_valid  <= 1'b1;
            res_x      <= pend_c - 1'b1;
            res_y      <= pend_r - 1'b1;
            res_closed <= 1'b0;
            res_empty  <= 1'b0;
            state      <= ST_IDLE;
          end else if (pend_valid && pend_last) begin
            // last pixel white: empty image
            active     <= 1'b0;
            pend_valid <= 1'b0;
            res_valid  <= 1'b1;
            res_x      <= '0;
            res_y      <= '0;
            res_closed <= 1'b0;
            res_empty  <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            pend_valid <= scan_issue;
            pend_last  <= scan_issue && scan_last;
            pend_c     <= sc;
            pend_r     <= sr;
            if (scan_issue) begin
              if (scan_last) begin
                scan_done <= 1'b1;
              end else if (sc == used_w) begin
                sc <= bict_pkg::COORD_W'(1);
                sr <= sr + 1'b1;
              end else begin
                sc <= sc + 1'b1;
              end
            end
          end
        end
        ST_FR: begin
          fl_black <= pix;
          state    <= ST_DEC;
        end
        ST_DEC: begin
          heading    <= heading_next;
          tracer_x   <= x_next;
          tracer_y   <= y_next;
          res_valid  <= 1'b1;
          res_x      <= x_next;
          res_y      <= y_next;
          res_closed <= (x_next == start_x) && (y_next == start_y);
          res_empty  <= 1'b0;
          if ((x_next == start_x) && (y_next == start_y)) begin
            active <= 1'b0;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/binary_image_contour_tracer.sv
// Contour tracer over a one-bit pixel store (single port, registered read).
// Pixel write: no result. Step: front-left read at accept, front-right read in
// ST_FR (one port), busy through ST_FR and ST_DEC, then the result strobe.
// Start: scan reads one pixel a cycle; result at the first black or the last pixel.
// Receiver cannot stall; each result strobes for exactly one cycle.
// Synchronous reset restores registers to 256 and clears the tracer; no store clear.
module binary_image_contour_tracer #(
  parameter int MAX_WIDTH  = bict_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bict_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bict_pkg::FUNC_W-1:0]   func,
  input  logic [bict_pkg::COORD_W-1:0]  pixel_col,
  input  logic [bict_pkg::COORD_W-1:0]  pixel_row,
  input  logic                          pixel_black,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bict_pkg::COORD_W-1:0]  cfg_data,
  output logic                          result_valid,
  output logic [bict_pkg::COORD_W-1:0]  corner_x,
  output logic [bict_pkg::COORD_W-1:0]  corner_y,
  output logic                          contour_closed,
  output logic                          image_empty
);

  logic [bict_pkg::COORD_W-1:0] image_width;
  logic [bict_pkg::COORD_W-1:0] image_height;
  logic [bict_pkg::COORD_W-1:0] used_w;
  logic [bict_pkg::COORD_W-1:0] used_h;
  bict_pkg::pix_req_t           req;
  bict_pkg::ctrl_stat_t         stat;
  logic                         pix;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bict_pkg::DIM_RESET;
      image_height <= bict_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bict_pkg::CFG_WIDTH:  image_width  <= cfg_data;
        bict_pkg::CFG_HEIGHT: image_height <= cfg_data;
      endcase
    end
  end

  // dimensions in use, clipped to the store
  always_comb begin
    if (bict_pkg::LIM_W'(image_width) > bict_pkg::LIM_W'(MAX_WIDTH)) begin
      used_w = bict_pkg::COORD_W'(MAX_WIDTH);
    end else begin
      used_w = image_width;
    end
    if (bict_pkg::LIM_W'(image_height) > bict_pkg::LIM_W'(MAX_HEIGHT)) begin
      used_h = bict_pkg::COORD_W'(MAX_HEIGHT);
    end else begin
      used_h = image_height;
    end
  end

  bict_pixel_mem #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_mem (
    .clk    (clk),
    .req    (req),
    .used_w (used_w),
    .used_h (used_h),
    .pix    (pix)
  );

  bict_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .func        (func),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .pixel_black (pixel_black),
    .used_w      (used_w),
    .used_h      (used_h),
    .pix         (pix),
    .req         (req),
    .stat        (stat),
    .res_valid   (result_valid),
    .res_x       (corner_x),
    .res_y       (corner_y),
    .res_closed  (contour_closed),
    .res_empty   (image_empty)
  );

  assign busy = stat.busy;

  // empty-image item carries the origin and never closes a contour
  a_empty_origin: assert property (@(posedge clk) disable iff (rst)
    result_valid && image_empty |-> corner_x == '0 && corner_y == '0 && !contour_closed)
    else $error("empty result with corner data");

  // a step accepted while tracing holds busy through ST_FR and ST_DEC
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func == bict_pkg::FUNC_STEP && stat.active |=> busy ##1 busy)
    else $error("step did not hold busy");

  // closing a contour ends the trace
  a_close_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && contour_closed |-> !stat.active)
    else $error("trace still active after closing");

  // pixel reads and writes never share a cycle
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(req.rd && req.we))
    else $error("store read and write together");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

  // unused command code, must be ignored
  localparam logic [bict_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int PX_W = bict_pkg::DEF_MAX_WIDTH;
  localparam int PX_H = bict_pkg::DEF_MAX_HEIGHT;
  // top-left window written before any read; every scan and trace stays in it
  localparam int WIN = 16;
  localparam int STEP_CAP = 80;
  localparam int RAND_ITEMS = 420;
  localparam int PHASE_ITEMS = 42;

  typedef struct packed {
    logic [bict_pkg::COORD_W-1:0] cx;
    logic [bict_pkg::COORD_W-1:0] cy;
    logic                         closed;
    logic                         empty_img;
  } corner_t;

  typedef struct packed {
    logic [bict_pkg::COORD_W-1:0] col;
    logic [bict_pkg::COORD_W-1:0] row;
  } pix_t;

  // Tracks the image, the tracer and the corners still owed by the block
  class corner_scoreboard;
    bit                           px [PX_H][PX_W];
    int unsigned                  img_w, img_h;
    logic [bict_pkg::COORD_W-1:0] tr_x, tr_y, org_x, org_y;
    logic [1:0]                   heading;
    bit                           active;
    corner_t                      corner_q[$];
    int unsigned                  errors;

    function new();
      img_w   = 32'(bict_pkg::DIM_RESET);
      img_h   = 32'(bict_pkg::DIM_RESET);
      tr_x    = '0;
      tr_y    = '0;
      org_x   = '0;
      org_y   = '0;
      heading = bict_pkg::HEAD_E;
      active  = 1'b0;
      errors  = 0;
    endfunction

    function void cfg_write(logic idx, logic [bict_pkg::COORD_W-1:0] val);
      if (idx == bict_pkg::CFG_WIDTH) img_w = 32'(val);
      else img_h = 32'(val);
    endfunction

    // anything outside the area in use reads white
    function bit pixel_at(int col, int row);
      int uw, uh;
      uw = (img_w > PX_W) ? PX_W : int'(img_w);
      uh = (img_h > PX_H) ? PX_H : int'(img_h);
      if (col < 1 || row < 1 || col > uw || row > uh) return 1'b0;
      return px[row-1][col-1];
    endfunction

    function bit ahead_left(logic [1:0] h);
      int dx, dy;
      case (h)
        bict_pkg::HEAD_N: begin dx = 0; dy = 0; end
        bict_pkg::HEAD_E: begin dx = 1; dy = 0; end
        bict_pkg::HEAD_S: begin dx = 1; dy = 1; end
        default:          begin dx = 0; dy = 1; end
      endcase
      return pixel_at(int'(tr_x) + dx, int'(tr_y) + dy);
    endfunction

    // row-major scan for the first black pixel
    function corner_t scan_start();
      int uw, uh, r, c;
      bit hit;
      uw  = (img_w > PX_W) ? PX_W : int'(img_w);
      uh  = (img_h > PX_H) ? PX_H : int'(img_h);
      r   = 1;
      c   = 1;
      hit = 1'b0;
      while (!hit && r <= uh) begin
        if (pixel_at(c, r)) begin
          hit = 1'b1;
        end else begin
          c++;
          if (c > uw) begin
            c = 1;
            r++;
          end
        end
      end
      if (hit) begin
        tr_x    = bict_pkg::COORD_W'(c - 1);
        tr_y    = bict_pkg::COORD_W'(r - 1);
        org_x   = tr_x;
        org_y   = tr_y;
        heading = bict_pkg::HEAD_E;
        active  = 1'b1;
        return '{cx: tr_x, cy: tr_y, closed: 1'b0, empty_img: 1'b0};
      end
      active = 1'b0;
      return '{cx: '0, cy: '0, closed: 1'b0, empty_img: 1'b1};
    endfunction

    // left if front-left is black, else right if front-right is white
    function corner_t trace_step();
      logic [1:0] rh;
      bit shut;
      rh = heading + 2'd1;
      if (ahead_left(heading)) heading = heading - 2'd1;
      else if (!ahead_left(rh)) heading = rh;
      case (heading)
        bict_pkg::HEAD_N: tr_y = tr_y - 9'd1;
        bict_pkg::HEAD_E: tr_x = tr_x + 9'd1;
        bict_pkg::HEAD_S: tr_y = tr_y + 9'd1;
        default:          tr_x = tr_x - 9'd1;
      endcase
      shut = (tr_x == org_x) && (tr_y == org_y);
      if (shut) active = 1'b0;
      return '{cx: tr_x, cy: tr_y, closed: shut, empty_img: 1'b0};
    endfunction

    // returns 1 when the item had any effect
    function bit note_item(logic [1:0] f, logic [bict_pkg::COORD_W-1:0] col,
                           logic [bict_pkg::COORD_W-1:0] row, logic blk);
      if (f == bict_pkg::FUNC_WRITE) begin
        if (col >= 1 && row >= 1 && col <= PX_W && row <= PX_H) begin
          px[row-1][col-1] = blk;
          return 1'b1;
        end
        return 1'b0;
      end
      if (f == bict_pkg::FUNC_START) begin
        corner_q.push_back(scan_start());
        return 1'b1;
      end
      if (f == bict_pkg::FUNC_STEP && active) begin
        corner_q.push_back(trace_step());
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void report(string what, corner_t e, corner_t g);
      errors++;
      if (errors <= 10)
        $display("%0t %s: exp x=%0d y=%0d closed=%0b empty=%0b, got x=%0d y=%0d %s",
                 $time, what, e.cx, e.cy, e.closed, e.empty_img, g.cx, g.cy,
                 $sformatf("closed=%0b empty=%0b", g.closed, g.empty_img));
    endfunction

    function void check_corner(corner_t got);
      corner_t want;
      if (corner_q.size() == 0) begin
        report("unexpected corner", '0, got);
        return;
      end
      want = corner_q.pop_front();
      if (got.cx !== want.cx || got.cy !== want.cy ||
          got.closed !== want.closed || got.empty_img !== want.empty_img)
        report("corner mismatch", want, got);
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [bict_pkg::FUNC_W-1:0]   func;
  logic [bict_pkg::COORD_W-1:0]  pixel_col;
  logic [bict_pkg::COORD_W-1:0]  pixel_row;
  logic                          pixel_black;
  logic                          cfg_we;
  logic                          cfg_index;
  logic [bict_pkg::COORD_W-1:0]  cfg_data;
  logic                          result_valid;
  logic [bict_pkg::COORD_W-1:0]  corner_x;
  logic [bict_pkg::COORD_W-1:0]  corner_y;
  logic                          contour_closed;
  logic                          image_empty;

  corner_scoreboard sb;
  pix_t             black_q[$];
  int unsigned      idle_pct;
  int unsigned      item_cnt;

  binary_image_contour_tracer u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .pixel_col      (pixel_col),
    .pixel_row      (pixel_row),
    .pixel_black    (pixel_black),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .result_valid   (result_valid),
    .corner_x       (corner_x),
    .corner_y       (corner_y),
    .contour_closed (contour_closed),
    .image_empty    (image_empty)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // corner monitor
  always @(posedge clk) begin
    if (!rst && result_valid)
      sb.check_corner('{cx: corner_x, cy: corner_y, closed: contour_closed,
                        empty_img: image_empty});
  end

  // one item, with an optional gap before it; called at a falling edge
  task automatic send_item(input logic [1:0] f,
                           input logic [bict_pkg::COORD_W-1:0] col,
                           input logic [bict_pkg::COORD_W-1:0] row, input logic blk);
    bit did;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(5, 1)) @(negedge clk);
    end
    start       <= 1'b1;
    func        <= f;
    pixel_col   <= col;
    pixel_row   <= row;
    pixel_black <= blk;
    @(posedge clk);
    while (busy) @(posedge clk);
    did = sb.note_item(f, col, row, blk);
    if (did) item_cnt++;
    @(negedge clk);
  endtask

  task automatic write_px(input int col, input int row, input logic blk);
    if (blk && col >= 1 && row >= 1 && col <= PX_W && row <= PX_H)
      black_q.push_back('{col: bict_pkg::COORD_W'(col), row: bict_pkg::COORD_W'(row)});
    send_item(bict_pkg::FUNC_WRITE, bict_pkg::COORD_W'(col), bict_pkg::COORD_W'(row), blk);
  endtask

  task automatic start_cmd();
    send_item(bict_pkg::FUNC_START, bict_pkg::COORD_W'($urandom_range(511)),
              bict_pkg::COORD_W'($urandom_range(511)), 1'($urandom_range(1)));
  endtask

  task automatic step_cmd();
    send_item(bict_pkg::FUNC_STEP, bict_pkg::COORD_W'($urandom_range(511)),
              bict_pkg::COORD_W'($urandom_range(511)), 1'($urandom_range(1)));
  endtask

  // wait for every owed corner, then let writes settle
  task automatic drain();
    start <= 1'b0;
    while (sb.corner_q.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_dims(input logic [bict_pkg::COORD_W-1:0] w,
                          input logic [bict_pkg::COORD_W-1:0] h);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= bict_pkg::CFG_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= bict_pkg::CFG_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.cfg_write(bict_pkg::CFG_WIDTH, w);
    sb.cfg_write(bict_pkg::CFG_HEIGHT, h);
  endtask

  // wipe the last blob, draw a new one, start and follow the contour
  task automatic run_trace();
    int   ew, eh, aw, ah, ww, wh, ox, oy, lim, n, steps, c, r;
    bit   want_empty;
    logic blk;
    pix_t p;
    ew = (sb.img_w > PX_W) ? PX_W : int'(sb.img_w);
    eh = (sb.img_h > PX_H) ? PX_H : int'(sb.img_h);
    if (ew == 0 || eh == 0) begin
      ew = 4;
      eh = 4;
    end
    // blob and the pixels round it stay inside the written window
    aw = (ew < WIN - 2) ? ew : WIN - 2;
    ah = (eh < WIN - 2) ? eh : WIN - 2;
    ww = $urandom_range((aw < 6) ? aw : 6, 1);
    wh = $urandom_range((ah < 6) ? ah : 6, 1);
    case ($urandom_range(3))
      0:       ox = 1;
      1:       ox = aw - ww + 1;
      default: ox = $urandom_range(aw - ww + 1, 1);
    endcase
    // rows wider than the window: the scan has to stop in the first row
    lim = (ew > WIN) ? 1 : ah - wh + 1;
    case ($urandom_range(3))
      0:       oy = 1;
      1:       oy = lim;
      default: oy = $urandom_range(lim, 1);
    endcase
    // an empty scan reads every pixel in use
    want_empty = (ew <= WIN) && (eh <= WIN) && ($urandom_range(7) == 0);

    while (black_q.size() != 0) begin
      p = black_q.pop_front();
      if (sb.px[p.row-1][p.col-1]) write_px(int'(p.col), int'(p.row), 1'b0);
    end
    if (!want_empty) begin
      n = $urandom_range((ww * wh < 8) ? ww * wh : 8, 1);
      repeat (n)
        write_px($urandom_range(ox + ww - 1, ox), $urandom_range(oy + wh - 1, oy), 1'b1);
      if ($urandom_range(2) == 0)
        write_px($urandom_range(ox + ww - 1, ox), $urandom_range(oy + wh - 1, oy), 1'b0);
      // top row of the box holds a black pixel, so the scan ends there
      write_px($urandom_range(ox + ww - 1, ox), oy, 1'b1);
    end
    start_cmd();

    steps = 0;
    while (sb.active && steps < STEP_CAP) begin
      case ($urandom_range(19))
        // image changes under the tracer
        0: write_px($urandom_range(ox + ww, ox - 1), $urandom_range(oy + wh, oy - 1),
                    1'($urandom_range(1)));
        1: send_item(FUNC_NONE, bict_pkg::COORD_W'($urandom_range(511)),
                     bict_pkg::COORD_W'($urandom_range(511)), 1'($urandom_range(1)));
        2: begin
          c = $urandom_range(511);
          r = $urandom_range(511);
          // black only well clear of the window, where the tracer never looks
          blk = (c > WIN + 2 || r > WIN + 2) ? 1'($urandom_range(1)) : 1'b0;
          write_px(c, r, blk);
        end
        default: begin
          step_cmd();
          steps++;
        end
      endcase
    end
    if ($urandom_range(3) == 0) step_cmd();
  endtask

  logic [bict_pkg::COORD_W-1:0] dim_w [10] = '{9'd8, 9'd1, 9'd256, 9'd3, 9'd0,
                                               9'd9, 9'd511, 9'd20, 9'd300, 9'd256};
  logic [bict_pkg::COORD_W-1:0] dim_h [10] = '{9'd8, 9'd1, 9'd12, 9'd256, 9'd9,
                                               9'd0, 9'd511, 9'd6, 9'd7, 9'd256};
  int unsigned                  pct_tab [4] = '{0, 48, 0, 8};

  initial begin
    int ph, target;
    sb          = new();
    rst         = 1'b1;
    start       = 1'b0;
    func        = bict_pkg::FUNC_WRITE;
    pixel_col   = '0;
    pixel_row   = '0;
    pixel_black = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = bict_pkg::CFG_WIDTH;
    cfg_data    = '0;
    idle_pct    = 0;
    item_cnt    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // store powers up undefined: whiten the window first
    for (int r = 1; r <= WIN; r++)
      for (int c = 1; c <= WIN; c++)
        send_item(bict_pkg::FUNC_WRITE, bict_pkg::COORD_W'(c), bict_pkg::COORD_W'(r), 1'b0);

    // single pixel at the corner: four steps close, then ignored items
    write_px(1, 1, 1'b1);
    start_cmd();
    repeat (4) step_cmd();
    step_cmd();
    send_item(FUNC_NONE, 9'd511, 9'd511, 1'b1);
    // pixel erased mid-trace: tracer wraps past column zero
    start_cmd();
    write_px(1, 1, 1'b0);
    repeat (4) step_cmd();
    // whole image white
    set_dims(bict_pkg::COORD_W'(WIN), bict_pkg::COORD_W'(WIN));
    start_cmd();
    // writes outside the store are dropped; far corner of the image kept
    write_px(0, 5, 1'b1);
    write_px(5, 0, 1'b1);
    write_px(257, 1, 1'b1);
    write_px(511, 511, 1'b1);
    write_px(256, 256, 1'b1);
    write_px(WIN, WIN, 1'b1);
    start_cmd();
    repeat (4) step_cmd();

    // random traces over a spread of image sizes
    item_cnt = 0;
    ph = 0;
    while (item_cnt < RAND_ITEMS) begin
      set_dims(dim_w[ph % 10], dim_h[ph % 10]);
      idle_pct = pct_tab[ph % 4];
      target = item_cnt + PHASE_ITEMS;
      while (item_cnt < target) run_trace();
      ph++;
    end

    start <= 1'b0;
    while (sb.corner_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.errors = sb.errors + $unsigned(sb.corner_q.size());
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #25_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
